### hdl/pvbs_pkg.sv
`default_nettype none
package pvbs_pkg;

	localparam int DATA_W = 24;
	localparam int BINS = 1024;
	localparam int IDX_W = $clog2(BINS);
	localparam int HOP_W = 11;
	localparam int PR_W = 14;
	localparam int PH_W = 16;
	localparam int CFG_W = 14;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_HOP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH = 1'b1;
	localparam logic [HOP_W-1:0] HOP_RST = 11'd256;
	localparam logic [PR_W-1:0] PITCH_RST = 14'd4096;

	localparam int HN_W = HOP_W + IDX_W;
	localparam int E_SH = PH_W - IDX_W;
	localparam int E_W = HN_W + E_SH;
	localparam int SUM_W = E_W + 1;
	localparam int PROD_W = SUM_W + PR_W;

	localparam int XW = 36;
	localparam int AW = 26;
	localparam int ZW = 26;
	localparam int CORDIC_STEPS = 20;
	localparam int HALF_TURN24 = 8388608;
	localparam int QUARTER_TURN24 = 4194304;

	localparam int SQ_W = 2 * DATA_W;
	localparam int SQRT_STEPS = DATA_W;
	localparam int MAG_W = DATA_W;
	localparam int K_W = 30;
	localparam logic [K_W-1:0] GAIN_INV = 30'd652032874;
	localparam int X0_W = 32;

	localparam int LAT_MAG = SQRT_STEPS + 4;
	localparam int LAT_VEC = CORDIC_STEPS + 2;
	localparam int LAT_UPD = 5;
	localparam int LAT_ROT = CORDIC_STEPS + 2;
	localparam int Z_DLY = LAT_MAG - LAT_VEC - LAT_UPD;
	localparam int LAT_TOTAL = LAT_MAG + LAT_ROT;

	typedef struct packed {
		logic signed [DATA_W-1:0] bin_real;
		logic signed [DATA_W-1:0] bin_imag;
		logic [IDX_W-1:0] bin_index;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_real;
		logic signed [DATA_W-1:0] out_imag;
	} out_item_t;

	function automatic logic [22:0] atan_turn(input logic [4:0] i);
		logic [22:0] r;
		case (i)
			5'd0: r = 23'd2097152;
			5'd1: r = 23'd1238021;
			5'd2: r = 23'd654136;
			5'd3: r = 23'd332050;
			5'd4: r = 23'd166669;
			5'd5: r = 23'd83416;
			5'd6: r = 23'd41718;
			5'd7: r = 23'd20860;
			5'd8: r = 23'd10430;
			5'd9: r = 23'd5215;
			5'd10: r = 23'd2608;
			5'd11: r = 23'd1304;
			5'd12: r = 23'd652;
			5'd13: r = 23'd326;
			5'd14: r = 23'd163;
			5'd15: r = 23'd81;
			5'd16: r = 23'd41;
			5'd17: r = 23'd20;
			5'd18: r = 23'd10;
			5'd19: r = 23'd5;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/pvbs_mag.sv
`default_nettype none
module pvbs_mag (
	input logic clk,
	input logic en,
	input logic signed [pvbs_pkg::DATA_W-1:0] re,
	input logic signed [pvbs_pkg::DATA_W-1:0] im,
	output logic [pvbs_pkg::X0_W-1:0] x0
);
	import pvbs_pkg::*;

	logic [SQ_W-1:0] sqr_s1;
	logic [SQ_W-1:0] sqi_s1;
	logic [SQ_W-1:0] rem_s [0:SQRT_STEPS];
	logic [SQ_W-1:0] root_s [0:SQRT_STEPS];
	logic [SQ_W-1:0] trial [0:SQRT_STEPS-1];
	logic [SQ_W-1:0] bitv [0:SQRT_STEPS-1];
	logic [MAG_W+K_W-1:0] prod_s;
	logic [MAG_W+K_W-1:0] prod_rnd;
	logic signed [SQ_W-1:0] sqr_full;
	logic signed [SQ_W-1:0] sqi_full;

	always_comb begin
		sqr_full = SQ_W'(re) * SQ_W'(re);
		sqi_full = SQ_W'(im) * SQ_W'(im);
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bitv[k] = SQ_W'(1) << (SQ_W - 2 - 2 * k);
			trial[k] = root_s[k] + bitv[k];
		end
		prod_rnd = prod_s + (MAG_W+K_W)'(1 << 21);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqr_s1 <= sqr_full;
			sqi_s1 <= sqi_full;
			rem_s[0] <= sqr_s1 + sqi_s1;
			root_s[0] <= '0;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				if (rem_s[k] >= trial[k]) begin
					rem_s[k+1] <= rem_s[k] - trial[k];
					root_s[k+1] <= (root_s[k] >> 1) + bitv[k];
				end else begin
					rem_s[k+1] <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
			prod_s <= (MAG_W+K_W)'(root_s[SQRT_STEPS][MAG_W-1:0]) * (MAG_W+K_W)'(GAIN_INV);
			x0 <= prod_rnd[X0_W+21:22];
		end
	end

endmodule
`default_nettype wire

### hdl/pvbs_cordic_vec.sv
`default_nettype none
module pvbs_cordic_vec (
	input logic clk,
	input logic en,
	input logic signed [pvbs_pkg::DATA_W-1:0] re,
	input logic signed [pvbs_pkg::DATA_W-1:0] im,
	output logic [pvbs_pkg::PH_W-1:0] ph
);
	import pvbs_pkg::*;

	logic signed [XW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] y_s [0:CORDIC_STEPS];
	logic signed [AW-1:0] a_s [0:CORDIC_STEPS];
	logic zero_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] x_in;
	logic signed [XW-1:0] y_in;
	logic signed [AW-1:0] ang_rnd;

	always_comb begin
		x_in = {{(XW-DATA_W-8){re[DATA_W-1]}}, re, 8'd0};
		y_in = {{(XW-DATA_W-8){im[DATA_W-1]}}, im, 8'd0};
		ang_rnd = a_s[CORDIC_STEPS] + AW'(128);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (re == '0) && (im == '0);
			if (re[DATA_W-1]) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				a_s[0] <= AW'(HALF_TURN24);
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				a_s[0] <= '0;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + $signed(AW'(atan_turn(5'(i))));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - $signed(AW'(atan_turn(5'(i))));
				end
			end
			ph <= zero_s[CORDIC_STEPS] ? '0 : ang_rnd[PH_W+7:8];
		end
	end

endmodule
`default_nettype wire

### hdl/pvbs_phase_upd.sv
`default_nettype none
module pvbs_phase_upd (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [pvbs_pkg::IDX_W-1:0] in_n,
	input logic [pvbs_pkg::E_W-1:0] in_e,
	input logic [pvbs_pkg::PH_W-1:0] in_ph,
	input logic [pvbs_pkg::PR_W-1:0] pitch,
	output logic [pvbs_pkg::PH_W-1:0] z
);
	import pvbs_pkg::*;

	logic [PH_W-1:0] prev_mem [0:BINS-1];
	logic [PH_W-1:0] synth_mem [0:BINS-1];
	logic first_q;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [IDX_W-1:0] n_s1, n_s2, n_s3, n_s4;
	logic [E_W-1:0] e_s1;
	logic [PH_W-1:0] ph_s1, ph_s2, ph_s3, ph_s4;
	logic [PH_W-1:0] prev_rd_s1, prev_fv_s1;
	logic prev_fwd_s1;
	logic [SUM_W-1:0] sum_s2;
	logic [SUM_W-1:0] prod_s3;
	logic [PH_W-1:0] inc_s4, synth_rd_s4, synth_fv_s4;
	logic synth_fwd_s4;

	logic [PH_W-1:0] prev_eff, dev, synth_eff, synth_new;
	logic [SUM_W-1:0] sum_c, rnd_c;
	logic [PROD_W-1:0] prod_full;

	always_comb begin
		prev_eff = prev_fwd_s1 ? prev_fv_s1 : prev_rd_s1;
		dev = ph_s1 - prev_eff - e_s1[PH_W-1:0];
		sum_c = {1'b0, e_s1} + {{(SUM_W-PH_W){dev[PH_W-1]}}, dev};
		prod_full = PROD_W'(sum_s2) * PROD_W'(pitch);
		rnd_c = prod_s3 + SUM_W'(2048);
		synth_eff = synth_fwd_s4 ? synth_fv_s4 : synth_rd_s4;
		synth_new = first_q ? ph_s4 : synth_eff + inc_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			first_q <= 1'b1;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4 && n_s4 == IDX_W'(BINS - 1)) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= in_n;
			e_s1 <= in_e;
			ph_s1 <= in_ph;
			prev_rd_s1 <= prev_mem[in_n];
			prev_fwd_s1 <= v_s1 && (n_s1 == in_n);
			prev_fv_s1 <= ph_s1;
			if (v_s1) begin
				prev_mem[n_s1] <= ph_s1;
			end
			n_s2 <= n_s1;
			ph_s2 <= ph_s1;
			sum_s2 <= sum_c;
			n_s3 <= n_s2;
			ph_s3 <= ph_s2;
			prod_s3 <= prod_full[SUM_W-1:0];
			n_s4 <= n_s3;
			ph_s4 <= ph_s3;
			inc_s4 <= rnd_c[SUM_W-1:SUM_W-PH_W];
			synth_rd_s4 <= synth_mem[n_s3];
			synth_fwd_s4 <= v_s4 && (n_s4 == n_s3);
			synth_fv_s4 <= synth_new;
			if (v_s4) begin
				synth_mem[n_s4] <= synth_new;
			end
			z <= synth_new;
		end
	end

endmodule
`default_nettype wire

### hdl/pvbs_cordic_rot.sv
`default_nettype none
module pvbs_cordic_rot (
	input logic clk,
	input logic en,
	input logic [pvbs_pkg::X0_W-1:0] x0,
	input logic [pvbs_pkg::PH_W-1:0] z,
	output pvbs_pkg::out_item_t res
);
	import pvbs_pkg::*;

	localparam logic signed [ZW-1:0] ZQ = ZW'(QUARTER_TURN24);
	localparam logic signed [ZW-1:0] ZH = ZW'(HALF_TURN24);

	logic signed [XW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] y_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] x_in;
	logic signed [ZW-1:0] z_in;
	logic signed [XW-1:0] xr, yr;

	function automatic logic signed [DATA_W-1:0] sat(input logic signed [XW-1:0] v);
		logic signed [XW-9:0] s;
		logic signed [DATA_W-1:0] r;
		s = v[XW-1:8];
		if (s > $signed((XW-8)'(8388607))) begin
			r = 24'sd8388607;
		end else if (s < -$signed((XW-8)'(8388608))) begin
			r = -24'sd8388608;
		end else begin
			r = s[DATA_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		x_in = XW'(x0);
		z_in = {{(ZW-PH_W-8){z[PH_W-1]}}, z, 8'd0};
		xr = x_s[CORDIC_STEPS] + XW'(128);
		yr = y_s[CORDIC_STEPS] + XW'(128);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s[0] <= '0;
			if (z_in > ZQ) begin
				z_s[0] <= z_in - ZH;
				x_s[0] <= -x_in;
			end else if (z_in < -ZQ) begin
				z_s[0] <= z_in + ZH;
				x_s[0] <= -x_in;
			end else begin
				z_s[0] <= z_in;
				x_s[0] <= x_in;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed(ZW'(atan_turn(5'(i))));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed(ZW'(atan_turn(5'(i))));
				end
			end
			res.out_real <= sat(xr);
			res.out_imag <= sat(yr);
		end
	end

endmodule
`default_nettype wire

### hdl/phase_vocoder_bin_shift_core.sv
`default_nettype none
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | in_data   (bin_real, bin_imag, bin_index)
// out     | out | out_valid / out_ready | out_data  (out_real, out_imag)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (0 hop_length, 1 pitch_ratio)
//
// One item per cycle unless a held result stalls the pipeline.
// Latency is set by the 24-step square root plus gain multiply (28 stages)
// followed by the 20-step rotation CORDIC (22 stages).
// Per-bin phase memories are read-modify-written with forwarding between adjacent
// items. Reset clears valid bits, sets the first-frame flag, loads hop/pitch defaults.
// A held result stalls the whole pipeline; nothing is dropped or repeated.
module phase_vocoder_bin_shift_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pvbs_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pvbs_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [pvbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pvbs_pkg::CFG_W-1:0] cfg_data
);
	import pvbs_pkg::*;

	logic en;
	logic [HOP_W-1:0] hop_q;
	logic [PR_W-1:0] pitch_q;
	logic [1:LAT_TOTAL] vld_s;
	logic [IDX_W-1:0] n_s [1:LAT_VEC];
	logic [HN_W-1:0] hn_s [1:LAT_VEC];
	logic [PH_W-1:0] zd_s [1:Z_DLY];
	logic [PH_W-1:0] z_upd;
	logic [HN_W-1:0] hn;
	logic [PH_W-1:0] ph;
	logic [X0_W-1:0] x0;

	assign en = !vld_s[LAT_TOTAL] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_s[LAT_TOTAL];
	assign cfg_ready = 1'b1;
	assign hn = HN_W'(hop_q) * HN_W'(in_data.bin_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q <= HOP_RST;
			pitch_q <= PITCH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HOP: hop_q <= cfg_data[HOP_W-1:0];
				REG_PITCH: pitch_q <= cfg_data[PR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {in_valid, vld_s[1:LAT_TOTAL-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[1] <= in_data.bin_index;
			hn_s[1] <= hn;
			for (int k = 2; k <= LAT_VEC; k++) begin
				n_s[k] <= n_s[k-1];
				hn_s[k] <= hn_s[k-1];
			end
			zd_s[1] <= z_upd;
			for (int k = 2; k <= Z_DLY; k++) begin
				zd_s[k] <= zd_s[k-1];
			end
		end
	end

	pvbs_mag u_mag (
		.clk(clk),
		.en(en),
		.re(in_data.bin_real),
		.im(in_data.bin_imag),
		.x0(x0)
	);

	pvbs_cordic_vec u_vec (
		.clk(clk),
		.en(en),
		.re(in_data.bin_real),
		.im(in_data.bin_imag),
		.ph(ph)
	);

	pvbs_phase_upd u_upd (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s[LAT_VEC]),
		.in_n(n_s[LAT_VEC]),
		.in_e({hn_s[LAT_VEC], {E_SH{1'b0}}}),
		.in_ph(ph),
		.pitch(pitch_q),
		.z(z_upd)
	);

	pvbs_cordic_rot u_rot (
		.clk(clk),
		.en(en),
		.x0(x0),
		.z(zd_s[Z_DLY]),
		.res(out_data)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[1])
		else $error("accepted item missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_s))
		else $error("pipeline moved during stall");

	a_blocked_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result held");

endmodule
`default_nettype wire
